[rtl/obxp_pkg.sv]
// ----------------------------------------------------------------------------
// obxp_pkg
// Shared types and constants of the OBEX response header parser.
// ----------------------------------------------------------------------------
package obxp_pkg;

    // Packet and header length fields are 16 bits wide
    localparam int unsigned LEN_W = 16;

    // Header walker phase
    typedef enum logic [2:0] {
        PH_ID      = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_ONE     = 3'd4,
        PH_FOUR    = 3'd5
    } t_phase;

    // Packet outcome reported on the last byte
    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_SUCCESS   = 3'd1,
        ST_CONTINUE  = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_MALFORMED = 3'd4
    } t_status;

    // Header id encoding (top two bits of the id)
    typedef enum logic [1:0] {
        ENC_TEXT  = 2'd0,
        ENC_BYTES = 2'd1,
        ENC_ONE   = 2'd2,
        ENC_FOUR  = 2'd3
    } t_enc;

    // Response codes and header ids
    localparam logic [7:0] CODE_SUCCESS  = 8'hA0;
    localparam logic [7:0] CODE_CONTINUE = 8'h90;
    localparam logic [7:0] HID_CONN_ID   = 8'hCB;
    localparam logic [7:0] HID_SRM       = 8'h97;
    localparam logic [7:0] HID_BODY      = 8'h48;
    localparam logic [7:0] HID_END_BODY  = 8'h49;
    localparam logic [7:0] SRM_ENABLE    = 8'h01;

    // Length limits
    localparam logic [LEN_W-1:0] MIN_PACKET_LEN     = 16'd3;
    localparam logic [LEN_W-1:0] CONNECT_PREFIX_LEN = 16'd7;
    localparam logic [LEN_W-1:0] HDR_MIN_LEN        = 16'd3;
    localparam logic [LEN_W-1:0] FOUR_HDR_LEN       = 16'd5;
    localparam logic [LEN_W-1:0] ONE_HDR_LEN        = 16'd2;
    localparam logic [LEN_W-1:0] FOUR_VALUE_BYTES   = 16'd4;
    localparam logic [LEN_W-1:0] MAX_PACKET_FLOOR   = 16'd255;
    localparam logic [LEN_W-1:0] MAX_PACKET_MIN_CAP = 16'd127;
    localparam logic [LEN_W-1:0] MAX_PACKET_RESET   = 16'd255;

    // Connect prefix byte offsets of the remote max packet
    localparam logic [LEN_W-1:0] POS_MAXPKT_HI = 16'd5;
    localparam logic [LEN_W-1:0] POS_MAXPKT_LO = 16'd6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT_CAP = 1'b1;

    // Header ids that the back end acts on
    typedef struct packed {
        logic is_body;
        logic is_srm;
        logic is_conn_id;
    } t_hid_cls;

    // Classification of one received byte
    typedef struct packed {
        t_enc     enc;
        t_hid_cls hid;
        logic     is_srm_on;
    } t_cls;

    // Queue entry between front and back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
        t_cls       cls;
    } t_item;

    // Configuration seen by the back end
    typedef struct packed {
        logic             connect_mode;
        logic [LEN_W-1:0] transport_cap;
    } t_cfg;

endpackage

[rtl/obex_response_header_parser.sv]
// ----------------------------------------------------------------------------
// obex_response_header_parser
// OBEX response packet parser, one received byte in and one result out per byte.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock while bytes arrive and the result side does
// not stall. A taken byte passes through the two-entry input queue and then
// loads the parser's result register; the header walker updates its state
// from each byte. While a result is stalled the queue keeps taking input until
// it holds two bytes. Configuration writes are taken every cycle (o_cfg_ready
// is tied high) and must only be issued while the parser is idle. Results of
// the remote max packet, connection id and SRM flag are the current values
// after the byte.
module obex_response_header_parser #(
    parameter int unsigned RX_BUFFER_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Received bytes
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_packet_start,
    // Results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_body_valid,
    output logic [7:0]                          o_body_data,
    output logic                                o_packet_end,
    output logic [2:0]                          o_status,
    output logic                                o_srm_enabled,
    output logic [31:0]                         o_connection_id,
    output logic [15:0]                         o_remote_max_packet,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [obxp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    logic                   r_connect_mode;
    logic [15:0]            r_transport_cap;
    obxp_pkg::t_cfg         w_cfg;
    logic                   w_q_valid;
    obxp_pkg::t_item        w_q_item;
    logic                   w_q_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connect_mode  <= 1'b0;
            r_transport_cap <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                obxp_pkg::CFG_CONNECT_MODE:  r_connect_mode  <= i_cfg_data[0];
                obxp_pkg::CFG_TRANSPORT_CAP: r_transport_cap <= i_cfg_data;
            endcase
        end
    end

    assign w_cfg = '{connect_mode: r_connect_mode, transport_cap: r_transport_cap};

    // Accept, classify and queue
    obxp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_packet_start (i_packet_start),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_pop        (w_q_pop)
    );

    // Parse and report
    obxp_back #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (w_q_valid),
        .i_q_item            (w_q_item),
        .o_q_pop             (w_q_pop),
        .i_cfg               (w_cfg),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_body_valid        (o_body_valid),
        .o_body_data         (o_body_data),
        .o_packet_end        (o_packet_end),
        .o_status            (o_status),
        .o_srm_enabled       (o_srm_enabled),
        .o_connection_id     (o_connection_id),
        .o_remote_max_packet (o_remote_max_packet)
    );

endmodule

[rtl/obxp_front.sv]
// ----------------------------------------------------------------------------
// obxp_front
// Accepts received bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module obxp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_packet_start,
    output logic               o_q_valid,
    output obxp_pkg::t_item    o_q_item,
    input  logic               i_q_pop
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    obxp_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    obxp_pkg::t_cls     w_cls;
    logic               w_push;

    // Classify the byte as a potential header id
    always_comb begin
        w_cls.enc            = obxp_pkg::t_enc'(i_rx_byte[7:6]);
        w_cls.hid.is_body    = (i_rx_byte == obxp_pkg::HID_BODY) ||
                               (i_rx_byte == obxp_pkg::HID_END_BODY);
        w_cls.hid.is_srm     = (i_rx_byte == obxp_pkg::HID_SRM);
        w_cls.hid.is_conn_id = (i_rx_byte == obxp_pkg::HID_CONN_ID);
        w_cls.is_srm_on      = (i_rx_byte == obxp_pkg::SRM_ENABLE);
    end

    assign o_in_stall = (r_count == CNT_W'(DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= '{rx_byte: i_rx_byte, packet_start: i_packet_start,
                               cls: w_cls};
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/obxp_back.sv]
// ----------------------------------------------------------------------------
// obxp_back
// Packet and header parser: one queued byte per cycle, while the result is not stalled, into the result register.
// ----------------------------------------------------------------------------
module obxp_back #(
    parameter int unsigned RX_BUFFER_BYTES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  obxp_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    input  obxp_pkg::t_cfg               i_cfg,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_body_valid,
    output logic [7:0]                   o_body_data,
    output logic                         o_packet_end,
    output logic [2:0]                   o_status,
    output logic                         o_srm_enabled,
    output logic [31:0]                  o_connection_id,
    output logic [obxp_pkg::LEN_W-1:0]   o_remote_max_packet
);

    localparam int unsigned LW = obxp_pkg::LEN_W;

    // Parser state
    logic [LW-1:0]          r_pos, n_pos;
    logic [LW-1:0]          r_plen, n_plen;
    logic [7:0]             r_rc, n_rc;
    obxp_pkg::t_hid_cls     r_hcls, n_hcls;
    obxp_pkg::t_phase       r_phase, n_phase;
    logic [LW-1:0]          r_hrem, n_hrem;
    logic [31:0]            r_vshift, n_vshift;
    logic                   r_stopped, n_stopped;
    logic                   r_srm, n_srm;
    logic [31:0]            r_conn, n_conn;
    logic [LW-1:0]          r_mp, n_mp;

    // Result register
    logic                   r_out_valid;
    logic                   r_body_valid, n_body_valid;
    logic [7:0]             r_body_data, n_body_data;
    logic                   r_end, n_end;
    obxp_pkg::t_status      r_status, n_status;

    // Step decode
    logic                   w_fire;
    logic [7:0]             w_b;
    logic                   w_start;
    logic                   w_run;
    logic                   w_at1;
    logic                   w_at2;
    logic [LW-1:0]          w_plen_next;
    logic                   w_len_bad;
    logic                   w_pre;
    logic                   w_rc_ok;
    logic                   w_hdr;
    logic [LW:0]            w_rem;
    logic [LW-1:0]          w_hlen;
    logic [LW+1:0]          w_hsum;
    logic                   w_hlen_bad;
    logic [LW-1:0]          w_hrem_dec;
    logic                   w_id_stop;
    logic [LW:0]            w_pos_inc;
    logic                   w_end;
    logic [LW-1:0]          w_mp_raw;
    logic [LW-1:0]          w_mp_floor;
    logic [LW-1:0]          w_cap_lim;
    logic [LW-1:0]          w_mp;
    logic                   w_mp_load;
    logic                   w_vs_hi;

    assign w_fire  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_fire;

    assign w_b     = i_q_item.rx_byte;
    assign w_start = i_q_item.packet_start;
    assign w_run   = !w_start && (r_pos != '0);
    assign w_at1   = (r_pos == LW'(1));
    assign w_at2   = (r_pos == LW'(2));
    assign w_rc_ok = (r_rc == obxp_pkg::CODE_SUCCESS);

    // Packet length assembly, big-endian
    always_comb begin
        priority if (w_at1) begin
            w_plen_next = {w_b, 8'h00};
        end else if (w_at2) begin
            w_plen_next = {r_plen[LW-1:8], w_b};
        end else begin
            w_plen_next = r_plen;
        end
    end

    assign w_len_bad = w_run && w_at2 &&
                       ((w_plen_next < obxp_pkg::MIN_PACKET_LEN) ||
                        ({1'b0, w_plen_next} > (LW+1)'(RX_BUFFER_BYTES)));

    // Connect prefix bytes (version, flags, max packet)
    assign w_pre = w_run && i_cfg.connect_mode && !w_at1 && !w_at2 &&
                   (r_pos < obxp_pkg::CONNECT_PREFIX_LEN);
    assign w_hdr = w_run && !w_at1 && !w_at2 && !w_pre && !r_stopped &&
                   (!i_cfg.connect_mode || w_rc_ok);

    // Header bounds checks
    assign w_rem      = {1'b0, r_plen} - {1'b0, r_pos};
    assign w_hlen     = {r_hrem[LW-1:8], w_b};
    assign w_hsum     = {2'b00, r_pos} - (LW+2)'(2) + {2'b00, w_hlen};
    assign w_hlen_bad = (w_hlen < obxp_pkg::HDR_MIN_LEN) || (w_hsum > {2'b00, r_plen});
    assign w_hrem_dec = r_hrem - LW'(1);

    always_comb begin
        unique case (i_q_item.cls.enc)
            obxp_pkg::ENC_FOUR: w_id_stop = (w_rem < {1'b0, obxp_pkg::FOUR_HDR_LEN});
            obxp_pkg::ENC_ONE:  w_id_stop = (w_rem < {1'b0, obxp_pkg::ONE_HDR_LEN});
            obxp_pkg::ENC_TEXT,
            obxp_pkg::ENC_BYTES: w_id_stop = (w_rem < {1'b0, obxp_pkg::HDR_MIN_LEN});
        endcase
    end

    // End of packet
    assign w_pos_inc = {1'b0, r_pos} + (LW+1)'(1);
    assign w_end     = w_len_bad ||
                       (w_run && !w_at1 && (w_pos_inc >= {1'b0, w_plen_next}));

    // Remote max packet: floor, then cap by the transport limit
    assign w_mp_raw   = {r_vshift[15:8], w_b};
    assign w_mp_floor = (w_mp_raw < obxp_pkg::MAX_PACKET_FLOOR) ?
                        obxp_pkg::MAX_PACKET_FLOOR : w_mp_raw;
    assign w_cap_lim  = (i_cfg.transport_cap < obxp_pkg::MAX_PACKET_MIN_CAP) ?
                        obxp_pkg::MAX_PACKET_MIN_CAP : i_cfg.transport_cap;
    assign w_mp       = ((i_cfg.transport_cap != '0) && (w_mp_floor > w_cap_lim)) ?
                        w_cap_lim : w_mp_floor;
    assign w_mp_load  = w_pre && (r_pos == obxp_pkg::POS_MAXPKT_LO) && w_rc_ok;
    assign w_vs_hi    = w_pre && (r_pos == obxp_pkg::POS_MAXPKT_HI);

    // Header phase next state
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (w_start) begin
                n_phase = obxp_pkg::PH_ID;
            end else if (w_hdr) begin
                unique case (r_phase)
                    obxp_pkg::PH_ID: begin
                        if (!w_id_stop) begin
                            unique case (i_q_item.cls.enc)
                                obxp_pkg::ENC_FOUR: n_phase = obxp_pkg::PH_FOUR;
                                obxp_pkg::ENC_ONE:  n_phase = obxp_pkg::PH_ONE;
                                obxp_pkg::ENC_TEXT,
                                obxp_pkg::ENC_BYTES: n_phase = obxp_pkg::PH_LEN_HI;
                            endcase
                        end
                    end
                    obxp_pkg::PH_LEN_HI: n_phase = obxp_pkg::PH_LEN_LO;
                    obxp_pkg::PH_LEN_LO: begin
                        n_phase = (w_hlen_bad || (w_hlen == obxp_pkg::HDR_MIN_LEN)) ?
                                  obxp_pkg::PH_ID : obxp_pkg::PH_PAYLOAD;
                    end
                    obxp_pkg::PH_PAYLOAD: begin
                        if (w_hrem_dec == '0) begin
                            n_phase = obxp_pkg::PH_ID;
                        end
                    end
                    obxp_pkg::PH_ONE: n_phase = obxp_pkg::PH_ID;
                    default: begin
                        if (w_hrem_dec == '0) begin
                            n_phase = obxp_pkg::PH_ID;
                        end
                    end
                endcase
            end
        end
    end

    // Packet and header datapath
    always_comb begin
        n_pos     = r_pos;
        n_plen    = r_plen;
        n_rc      = r_rc;
        n_hcls    = r_hcls;
        n_hrem    = r_hrem;
        n_vshift  = r_vshift;
        n_stopped = r_stopped;
        n_srm     = r_srm;
        n_conn    = r_conn;
        n_mp      = r_mp;
        if (w_fire) begin
            if (w_start) begin
                n_rc      = w_b;
                n_pos     = LW'(1);
                n_plen    = '0;
                n_hrem    = '0;
                n_vshift  = '0;
                n_stopped = 1'b0;
            end else if (r_pos != '0) begin
                n_plen = w_plen_next;
                n_pos  = w_end ? '0 : w_pos_inc[LW-1:0];
                if (w_vs_hi) begin
                    n_vshift = {16'h0000, w_b, 8'h00};
                end
                if (w_mp_load) begin
                    n_mp     = w_mp;
                    n_vshift = '0;
                end
                if (w_hdr) begin
                    unique case (r_phase)
                        obxp_pkg::PH_ID: begin
                            n_hcls = i_q_item.cls.hid;
                            if (w_id_stop) begin
                                n_stopped = 1'b1;
                            end else if (i_q_item.cls.enc == obxp_pkg::ENC_FOUR) begin
                                n_hrem   = obxp_pkg::FOUR_VALUE_BYTES;
                                n_vshift = '0;
                            end
                        end
                        obxp_pkg::PH_LEN_HI: n_hrem = {w_b, 8'h00};
                        obxp_pkg::PH_LEN_LO: begin
                            if (w_hlen_bad) begin
                                n_stopped = 1'b1;
                            end else begin
                                n_hrem = w_hlen - obxp_pkg::HDR_MIN_LEN;
                            end
                        end
                        obxp_pkg::PH_PAYLOAD: n_hrem = w_hrem_dec;
                        obxp_pkg::PH_ONE: begin
                            if (!i_cfg.connect_mode && r_hcls.is_srm &&
                                i_q_item.cls.is_srm_on) begin
                                n_srm = 1'b1;
                            end
                        end
                        default: begin
                            n_vshift = {r_vshift[23:0], w_b};
                            n_hrem   = w_hrem_dec;
                            if ((w_hrem_dec == '0) && i_cfg.connect_mode &&
                                r_hcls.is_conn_id) begin
                                n_conn = {r_vshift[23:0], w_b};
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Result fields of this step
    always_comb begin
        n_body_valid = w_hdr && (r_phase == obxp_pkg::PH_PAYLOAD) &&
                       !i_cfg.connect_mode && r_hcls.is_body;
        n_body_data  = n_body_valid ? w_b : 8'h00;
        n_end        = w_end;
        priority if (!w_end) begin
            n_status = obxp_pkg::ST_PENDING;
        end else if (w_len_bad) begin
            n_status = obxp_pkg::ST_MALFORMED;
        end else if (i_cfg.connect_mode) begin
            if (w_plen_next < obxp_pkg::CONNECT_PREFIX_LEN) begin
                n_status = obxp_pkg::ST_MALFORMED;
            end else begin
                n_status = w_rc_ok ? obxp_pkg::ST_SUCCESS : obxp_pkg::ST_REJECTED;
            end
        end else if (w_rc_ok) begin
            n_status = obxp_pkg::ST_SUCCESS;
        end else if (r_rc == obxp_pkg::CODE_CONTINUE) begin
            n_status = obxp_pkg::ST_CONTINUE;
        end else begin
            n_status = obxp_pkg::ST_REJECTED;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_plen      <= '0;
            r_rc        <= '0;
            r_hcls      <= '0;
            r_phase     <= obxp_pkg::PH_ID;
            r_hrem      <= '0;
            r_vshift    <= '0;
            r_stopped   <= 1'b0;
            r_srm       <= 1'b0;
            r_conn      <= '0;
            r_mp        <= obxp_pkg::MAX_PACKET_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_plen    <= n_plen;
            r_rc      <= n_rc;
            r_hcls    <= n_hcls;
            r_phase   <= n_phase;
            r_hrem    <= n_hrem;
            r_vshift  <= n_vshift;
            r_stopped <= n_stopped;
            r_srm     <= n_srm;
            r_conn    <= n_conn;
            r_mp      <= n_mp;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_body_valid <= n_body_valid;
            r_body_data  <= n_body_data;
            r_end        <= n_end;
            r_status     <= n_status;
        end
    end

    // Sticky fields change only when a new result loads, so they drive out directly
    assign o_out_valid         = r_out_valid;
    assign o_body_valid        = r_body_valid;
    assign o_body_data         = r_body_data;
    assign o_packet_end        = r_end;
    assign o_status            = r_status;
    assign o_srm_enabled       = r_srm;
    assign o_connection_id     = r_conn;
    assign o_remote_max_packet = r_mp;

endmodule

[rtl/obxp_checker.sv]
// ----------------------------------------------------------------------------
// obxp_checker
// Port-level checks of the OBEX response header parser, bound to the top level.
// ----------------------------------------------------------------------------
module obxp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_body_valid,
    input  logic [7:0]  o_body_data,
    input  logic        o_packet_end,
    input  logic [2:0]  o_status,
    input  logic        o_srm_enabled,
    input  logic [15:0] o_remote_max_packet
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_body_data) && $stable(o_status) &&
             $stable(o_packet_end) && $stable(o_body_valid)))
        else $error("result changed while stalled");

    // An outcome is reported exactly on the packet's last transaction
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_packet_end == (o_status != obxp_pkg::ST_PENDING)))
        else $error("status and packet end disagree");

    // Body data is zero unless it carries a payload byte
    a_body_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_body_valid) |-> (o_body_data == 8'h00))
        else $error("body data without body valid");

    // Remote max packet never drops below the minimum cap
    a_mp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_remote_max_packet >= obxp_pkg::MAX_PACKET_MIN_CAP)
        else $error("remote max packet below minimum");

    // SRM, once enabled, stays enabled until reset
    a_srm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_srm_enabled |=> o_srm_enabled)
        else $error("SRM flag cleared");

endmodule

bind obex_response_header_parser obxp_checker u_obxp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_body_valid        (o_body_valid),
    .o_body_data         (o_body_data),
    .o_packet_end        (o_packet_end),
    .o_status            (o_status),
    .o_srm_enabled       (o_srm_enabled),
    .o_remote_max_packet (o_remote_max_packet)
);

[tb/sv/obex_response_header_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obex_response_header_parser_tb
// Self-checking bench for the OBEX response header parser.
// A short table of hand-picked bytes runs first: bad lengths, restart,
// continue, SRM and body in get mode, capped max packet and short connect in
// connect mode. Random response packets follow, over several settings of
// connect mode and transport cap: mostly well-formed packets with random
// headers, plus bad lengths, truncated, overrunning and short packets and
// stray bytes. Each accepted byte runs through a local parser model and every
// result transaction is checked field by field, in order. Random idle bursts
// on both sides, none in the last part.
// ----------------------------------------------------------------------------
module obex_response_header_parser_tb;

    localparam int unsigned RX_BUFFER_BYTES = 4096;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned ITEMS_PER_PHASE = 80;
    localparam int unsigned N_PHASES        = 6;

    // One result transaction
    typedef struct packed {
        logic              body_valid;
        logic [7:0]        body_data;
        logic              packet_end;
        obxp_pkg::t_status status;
        logic              srm;
        logic [31:0]       conn_id;
        logic [15:0]       max_pkt;
    } t_exp;

    typedef enum logic {ROW_RX, ROW_CFG} t_row_kind;

    // One row of the directed table
    typedef struct packed {
        t_row_kind                      kind;
        logic [7:0]                     rx;
        logic                           start;
        logic [obxp_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [15:0]                    cfg_val;
        logic                           lit;
        t_exp                           want;
    } t_step_row;

    // DUT signals
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [7:0]                     i_rx_byte = '0;
    logic                           i_packet_start = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_body_valid;
    logic [7:0]                     o_body_data;
    logic                           o_packet_end;
    logic [2:0]                     o_status;
    logic                           o_srm_enabled;
    logic [31:0]                    o_connection_id;
    logic [15:0]                    o_remote_max_packet;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [obxp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]                    i_cfg_data = '0;

    // Parser model state, reset values
    logic [15:0]        rx_pos = '0;
    logic [15:0]        pkt_len = '0;
    logic [7:0]         rsp_code = '0;
    logic [7:0]         hdr_id = '0;
    obxp_pkg::t_phase   hdr_phase = obxp_pkg::PH_ID;
    logic [15:0]        hdr_left = '0;
    logic [31:0]        val_acc = '0;
    logic               walk_halted = 1'b0;
    logic               srm_q = 1'b0;
    logic [31:0]        conn_id_q = '0;
    logic [15:0]        max_pkt_q = obxp_pkg::MAX_PACKET_RESET;
    logic               cfg_connect = 1'b0;
    logic [15:0]        cfg_cap = '0;

    t_exp           rsp_q[$];
    t_exp           rsp_head;
    t_step_row      dir_tbl[$];
    int unsigned    fail_cnt = 0;
    int unsigned    cycle_cnt = 0;
    int unsigned    pkt_items = 0;
    int unsigned    stall_left = 0;
    bit             gaps_on = 1'b1;

    obex_response_header_parser #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .i_packet_start      (i_packet_start),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_body_valid        (o_body_valid),
        .o_body_data         (o_body_data),
        .o_packet_end        (o_packet_end),
        .o_status            (o_status),
        .o_srm_enabled       (o_srm_enabled),
        .o_connection_id     (o_connection_id),
        .o_remote_max_packet (o_remote_max_packet),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Parse one received byte, advance the model, return the expected result
    function automatic t_exp parse_rx_byte(input logic [7:0] b, input logic s);
        t_exp        r;
        int unsigned p;
        int unsigned rem;
        int unsigned hlen;
        int unsigned mp;
        int unsigned lim;
        r = '0;
        r.status = obxp_pkg::ST_PENDING;
        if (s) begin
            rsp_code    = b;
            rx_pos      = 16'd1;
            pkt_len     = '0;
            hdr_phase   = obxp_pkg::PH_ID;
            hdr_left    = '0;
            val_acc     = '0;
            walk_halted = 1'b0;
        end else if (rx_pos != 0) begin
            p = rx_pos;
            if (p == 1) begin
                pkt_len = {b, 8'h00};
            end else if (p == 2) begin
                pkt_len[7:0] = b;
                if (pkt_len < obxp_pkg::MIN_PACKET_LEN || pkt_len > RX_BUFFER_BYTES) begin
                    r.packet_end = 1'b1;
                    r.status     = obxp_pkg::ST_MALFORMED;
                end
            end else if (cfg_connect && p < obxp_pkg::CONNECT_PREFIX_LEN) begin
                // connect prefix: version, flags, max packet
                if (p == obxp_pkg::POS_MAXPKT_HI) begin
                    val_acc = {16'h0000, b, 8'h00};
                end else if (p == obxp_pkg::POS_MAXPKT_LO &&
                             rsp_code == obxp_pkg::CODE_SUCCESS) begin
                    mp = val_acc | b;
                    if (mp < obxp_pkg::MAX_PACKET_FLOOR) mp = obxp_pkg::MAX_PACKET_FLOOR;
                    if (cfg_cap != 0) begin
                        lim = (cfg_cap < obxp_pkg::MAX_PACKET_MIN_CAP) ?
                              obxp_pkg::MAX_PACKET_MIN_CAP : cfg_cap;
                        if (mp > lim) mp = lim;
                    end
                    max_pkt_q = mp[15:0];
                    val_acc   = '0;
                end
            end else if (!walk_halted &&
                         (!cfg_connect || rsp_code == obxp_pkg::CODE_SUCCESS)) begin
                // header walk
                rem = pkt_len - p;
                case (hdr_phase)
                    obxp_pkg::PH_ID: begin
                        hdr_id = b;
                        case (obxp_pkg::t_enc'(b[7:6]))
                            obxp_pkg::ENC_FOUR: begin
                                if (rem < obxp_pkg::FOUR_HDR_LEN) begin
                                    walk_halted = 1'b1;
                                end else begin
                                    hdr_phase = obxp_pkg::PH_FOUR;
                                    hdr_left  = obxp_pkg::FOUR_VALUE_BYTES;
                                    val_acc   = '0;
                                end
                            end
                            obxp_pkg::ENC_ONE: begin
                                if (rem < obxp_pkg::ONE_HDR_LEN) walk_halted = 1'b1;
                                else hdr_phase = obxp_pkg::PH_ONE;
                            end
                            default: begin
                                if (rem < obxp_pkg::HDR_MIN_LEN) walk_halted = 1'b1;
                                else hdr_phase = obxp_pkg::PH_LEN_HI;
                            end
                        endcase
                    end
                    obxp_pkg::PH_LEN_HI: begin
                        hdr_left  = {b, 8'h00};
                        hdr_phase = obxp_pkg::PH_LEN_LO;
                    end
                    obxp_pkg::PH_LEN_LO: begin
                        hlen = {hdr_left[15:8], b};
                        if (hlen < obxp_pkg::HDR_MIN_LEN || (p - 2) + hlen > pkt_len) begin
                            walk_halted = 1'b1;
                            hdr_phase   = obxp_pkg::PH_ID;
                        end else begin
                            hdr_left  = 16'(hlen - obxp_pkg::HDR_MIN_LEN);
                            hdr_phase = (hdr_left != 0) ? obxp_pkg::PH_PAYLOAD :
                                                          obxp_pkg::PH_ID;
                        end
                    end
                    obxp_pkg::PH_PAYLOAD: begin
                        if (!cfg_connect && (hdr_id == obxp_pkg::HID_BODY ||
                                             hdr_id == obxp_pkg::HID_END_BODY)) begin
                            r.body_valid = 1'b1;
                            r.body_data  = b;
                        end
                        hdr_left = hdr_left - 16'd1;
                        if (hdr_left == 0) hdr_phase = obxp_pkg::PH_ID;
                    end
                    obxp_pkg::PH_ONE: begin
                        if (!cfg_connect && hdr_id == obxp_pkg::HID_SRM &&
                            b == obxp_pkg::SRM_ENABLE) srm_q = 1'b1;
                        hdr_phase = obxp_pkg::PH_ID;
                    end
                    default: begin
                        val_acc  = {val_acc[23:0], b};
                        hdr_left = hdr_left - 16'd1;
                        if (hdr_left == 0) begin
                            if (cfg_connect && hdr_id == obxp_pkg::HID_CONN_ID)
                                conn_id_q = val_acc;
                            hdr_phase = obxp_pkg::PH_ID;
                        end
                    end
                endcase
            end

            // last byte of the packet: report the outcome
            if (!r.packet_end && p >= 2 && p + 1 >= pkt_len) begin
                r.packet_end = 1'b1;
                if (cfg_connect) begin
                    if (pkt_len < obxp_pkg::CONNECT_PREFIX_LEN)
                        r.status = obxp_pkg::ST_MALFORMED;
                    else if (rsp_code == obxp_pkg::CODE_SUCCESS)
                        r.status = obxp_pkg::ST_SUCCESS;
                    else
                        r.status = obxp_pkg::ST_REJECTED;
                end else if (rsp_code == obxp_pkg::CODE_SUCCESS) begin
                    r.status = obxp_pkg::ST_SUCCESS;
                end else if (rsp_code == obxp_pkg::CODE_CONTINUE) begin
                    r.status = obxp_pkg::ST_CONTINUE;
                end else begin
                    r.status = obxp_pkg::ST_REJECTED;
                end
            end
            rx_pos = r.packet_end ? 16'd0 : 16'(p + 1);
        end
        r.srm     = srm_q;
        r.conn_id = conn_id_q;
        r.max_pkt = max_pkt_q;
        return r;
    endfunction

    // Table row builders
    function automatic t_exp rsp(input logic pe, input obxp_pkg::t_status st,
                                 input logic srm, input logic [31:0] cid,
                                 input logic [15:0] mp);
        t_exp r;
        r            = '0;
        r.packet_end = pe;
        r.status     = st;
        r.srm        = srm;
        r.conn_id    = cid;
        r.max_pkt    = mp;
        return r;
    endfunction

    function automatic t_step_row rx_row(input logic [7:0] b, input logic s);
        t_step_row row;
        row       = '0;
        row.kind  = ROW_RX;
        row.rx    = b;
        row.start = s;
        return row;
    endfunction

    function automatic t_step_row rx_lit(input logic [7:0] b, input logic s, input t_exp w);
        t_step_row row;
        row      = rx_row(b, s);
        row.lit  = 1'b1;
        row.want = w;
        return row;
    endfunction

    function automatic t_step_row cfg_row(input logic [obxp_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [15:0] val);
        t_step_row row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // Send one byte transaction; queue the typed result or the model's one
    task automatic send_rx(input logic [7:0] b, input logic s, input logic lit,
                           input t_exp w);
        t_exp pred;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_rx_byte      <= b;
        i_packet_start <= s;
        do @(posedge i_clk); while (o_in_stall);
        pred = parse_rx_byte(b, s);
        rsp_q.push_back(lit ? w : pred);
    endtask

    // Register write, only once the parser has drained
    task automatic write_reg(input logic [obxp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_in_valid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == obxp_pkg::CFG_CONNECT_MODE) cfg_connect = val[0];
        else cfg_cap = val;
    endtask

    // One random response packet, well-formed or broken
    task automatic send_response();
        logic [7:0]  pkt[$];
        logic [7:0]  code;
        logic [15:0] len;
        logic [15:0] mp;
        logic [15:0] hlen;
        int unsigned pre;
        int unsigned plen;
        int unsigned sel;
        int unsigned form;
        int unsigned n_send;
        pkt = {};
        sel = $urandom_range(0, 9);
        if (sel < 5) code = obxp_pkg::CODE_SUCCESS;
        else if (sel < 7) code = obxp_pkg::CODE_CONTINUE;
        else code = 8'($urandom);
        pkt.push_back(code);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        if (cfg_connect) begin
            case ($urandom_range(0, 3))
                0: mp = 16'($urandom_range(0, 254));
                1: mp = 16'($urandom);
                2: mp = 16'hFFFF;
                default: mp = 16'($urandom_range(255, 1023));
            endcase
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
            pkt.push_back(mp[15:8]);
            pkt.push_back(mp[7:0]);
        end
        pre = pkt.size();

        // headers
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 12))
                0, 1, 2: begin
                    plen = $urandom_range(0, 5);
                    pkt.push_back($urandom_range(0, 1) ? obxp_pkg::HID_BODY :
                                                         obxp_pkg::HID_END_BODY);
                    pkt.push_back(8'h00);
                    pkt.push_back(8'(plen + 3));
                    repeat (plen) pkt.push_back(8'($urandom));
                end
                3, 4: begin
                    pkt.push_back(obxp_pkg::HID_SRM);
                    pkt.push_back($urandom_range(0, 2) != 0 ? obxp_pkg::SRM_ENABLE :
                                                              8'($urandom));
                end
                5, 6: begin
                    pkt.push_back(obxp_pkg::HID_CONN_ID);
                    repeat (4) pkt.push_back(8'($urandom));
                end
                7: begin
                    pkt.push_back({2'b10, 6'($urandom)});
                    pkt.push_back(8'($urandom));
                end
                8: begin
                    pkt.push_back({2'b11, 6'($urandom)});
                    repeat (4) pkt.push_back(8'($urandom));
                end
                9, 10: begin
                    plen = $urandom_range(0, 4);
                    pkt.push_back({1'b0, 7'($urandom)});
                    pkt.push_back(8'h00);
                    pkt.push_back(8'(plen + 3));
                    repeat (plen) pkt.push_back(8'($urandom));
                end
                default: begin
                    // header length too short or past the packet end
                    hlen = $urandom_range(0, 1) ? 16'($urandom_range(0, 2)) : 16'($urandom);
                    pkt.push_back({1'b0, 7'($urandom)});
                    pkt.push_back(hlen[15:8]);
                    pkt.push_back(hlen[7:0]);
                    repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
                end
            endcase
        end

        len    = 16'(pkt.size());
        n_send = pkt.size();
        form   = $urandom_range(0, 19);
        case (form)
            0: begin
                // bad length field
                case ($urandom_range(0, 3))
                    0: len = 16'($urandom_range(0, 2));
                    1: len = 16'(RX_BUFFER_BYTES + 1);
                    2: len = 16'hFFFF;
                    default: len = 16'($urandom_range(RX_BUFFER_BYTES + 1, 65535));
                endcase
                n_send = 3;
            end
            1: begin
                // cut short, the next packet start drops it
                if ($urandom_range(0, 1)) len = 16'(RX_BUFFER_BYTES);
                n_send = $urandom_range(1, pkt.size());
            end
            2: begin
                // last header runs past the packet end
                if (pkt.size() > pre) begin
                    plen   = pkt.size() - pre;
                    len    = 16'(pkt.size() - $urandom_range(1, plen < 4 ? plen : 4));
                    n_send = len;
                end
            end
            3: begin
                len    = 16'($urandom_range(3, 6));
                n_send = len;
            end
            4: begin
                // stray bytes between packets
                repeat ($urandom_range(1, 3))
                    send_rx(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
            end
            default: ;
        endcase
        pkt[1] = len[15:8];
        pkt[2] = len[7:0];
        while (pkt.size() < n_send) pkt.push_back(8'($urandom));
        for (int unsigned i = 0; i < n_send; i++)
            send_rx(pkt[i], i == 0, 1'b0, '0);
        pkt_items += n_send;
    endtask

    task automatic check_field(input string fld, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_cnt++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fld, want, got);
        end
    endtask

    // Result check and output stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: result with none expected, end %0b status %0d",
                         $time, o_packet_end, o_status);
            end else begin
                rsp_head = rsp_q.pop_front();
                check_field("body_valid", 32'(rsp_head.body_valid), 32'(o_body_valid));
                check_field("body_data", 32'(rsp_head.body_data), 32'(o_body_data));
                check_field("packet_end", 32'(rsp_head.packet_end), 32'(o_packet_end));
                check_field("status", 32'(rsp_head.status), 32'(o_status));
                check_field("srm_enabled", 32'(rsp_head.srm), 32'(o_srm_enabled));
                check_field("connection_id", rsp_head.conn_id, o_connection_id);
                check_field("remote_max_packet", 32'(rsp_head.max_pkt),
                            32'(o_remote_max_packet));
            end
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Timeout
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[obex_response_header_parser] ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        // get mode after reset: stray byte, bad lengths, restart, continue
        dir_tbl.push_back(rx_lit(8'hFF, 1'b0,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'h00, 1'b1,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'h00, 1'b0,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'h02, 1'b0,
            rsp(1'b1, obxp_pkg::ST_MALFORMED, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'hFF, 1'b1,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'hFF, 1'b0,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'hFF, 1'b0,
            rsp(1'b1, obxp_pkg::ST_MALFORMED, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_row(obxp_pkg::CODE_SUCCESS, 1'b1));
        dir_tbl.push_back(rx_lit(obxp_pkg::CODE_CONTINUE, 1'b1,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'h00, 1'b0,
            rsp(1'b0, obxp_pkg::ST_PENDING, 1'b0, 0, 16'd255)));
        dir_tbl.push_back(rx_lit(8'h03, 1'b0,
            rsp(1'b1, obxp_pkg::ST_CONTINUE, 1'b0, 0, 16'd255)));
        // success with SRM on and a one-byte body
        dir_tbl.push_back(rx_row(obxp_pkg::CODE_SUCCESS, 1'b1));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h09, 1'b0));
        dir_tbl.push_back(rx_row(obxp_pkg::HID_SRM, 1'b0));
        dir_tbl.push_back(rx_row(obxp_pkg::SRM_ENABLE, 1'b0));
        dir_tbl.push_back(rx_row(obxp_pkg::HID_BODY, 1'b0));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h04, 1'b0));
        dir_tbl.push_back(rx_row(8'hAA, 1'b0));
        // rejected code, four-byte header past the end halts the walk
        dir_tbl.push_back(rx_row(8'h00, 1'b1));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h05, 1'b0));
        dir_tbl.push_back(rx_row(8'hC0, 1'b0));
        dir_tbl.push_back(rx_lit(8'h12, 1'b0,
            rsp(1'b1, obxp_pkg::ST_REJECTED, 1'b1, 0, 16'd255)));
        // connect mode, cap below the minimum: max packet 5 -> 255 -> 127
        dir_tbl.push_back(cfg_row(obxp_pkg::CFG_CONNECT_MODE, 16'd1));
        dir_tbl.push_back(cfg_row(obxp_pkg::CFG_TRANSPORT_CAP, 16'd100));
        dir_tbl.push_back(rx_row(obxp_pkg::CODE_SUCCESS, 1'b1));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h07, 1'b0));
        dir_tbl.push_back(rx_row(8'h10, 1'b0));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_lit(8'h05, 1'b0,
            rsp(1'b1, obxp_pkg::ST_SUCCESS, 1'b1, 0, 16'd127)));
        // short connect
        dir_tbl.push_back(rx_row(obxp_pkg::CODE_SUCCESS, 1'b1));
        dir_tbl.push_back(rx_row(8'h00, 1'b0));
        dir_tbl.push_back(rx_row(8'h04, 1'b0));
        dir_tbl.push_back(rx_lit(8'h00, 1'b0,
            rsp(1'b1, obxp_pkg::ST_MALFORMED, 1'b1, 0, 16'd127)));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG)
                write_reg(dir_tbl[i].cfg_idx, dir_tbl[i].cfg_val);
            else
                send_rx(dir_tbl[i].rx, dir_tbl[i].start, dir_tbl[i].lit, dir_tbl[i].want);
        end

        // random phases, each under its own register setting
        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(obxp_pkg::CFG_CONNECT_MODE, {15'($urandom), 1'b0});
                    write_reg(obxp_pkg::CFG_TRANSPORT_CAP, 16'd0);
                end
                1: write_reg(obxp_pkg::CFG_CONNECT_MODE, {15'($urandom), 1'b1});
                2: write_reg(obxp_pkg::CFG_TRANSPORT_CAP, 16'd1);
                3: write_reg(obxp_pkg::CFG_TRANSPORT_CAP, 16'hFFFF);
                4: write_reg(obxp_pkg::CFG_TRANSPORT_CAP, 16'($urandom_range(127, 2000)));
                default: begin
                    write_reg(obxp_pkg::CFG_CONNECT_MODE, 16'd0);
                    write_reg(obxp_pkg::CFG_TRANSPORT_CAP, 16'($urandom));
                end
            endcase
            pkt_items = 0;
            while (pkt_items < ITEMS_PER_PHASE) begin
                gaps_on = (ph != N_PHASES - 1) && ($urandom_range(0, 4) != 0);
                send_response();
            end
        end

        // drain and settle
        gaps_on = 1'b0;
        i_in_valid <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[obex_response_header_parser] OK");
        else
            $display("[obex_response_header_parser] ERROR");
        $finish;
    end

endmodule
